/* design/sitda_pkg.sv */
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned CONV_CNT_W = $clog2(DATA_W);
    localparam int unsigned LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'd45;
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_DIGITS
    } t_state;

    // Control shared by every cell of the digit chain.
    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } t_cell_ctl;

endpackage

/* design/sitda_digit_cell.sv */
// ----------------------------------------------------------------------------
// sitda_digit_cell
// One BCD digit of the conversion chain: shift-add-3 step or digit shift.
// ----------------------------------------------------------------------------
module sitda_digit_cell (
    input  logic                              i_clk,
    input  sitda_pkg::t_cell_ctl              i_ctl,
    input  logic                              i_bit,
    input  logic [sitda_pkg::DIGIT_W-1:0]     i_digit,
    output logic                              o_bit,
    output logic [sitda_pkg::DIGIT_W-1:0]     o_digit
);

    logic [sitda_pkg::DIGIT_W-1:0] r_digit;
    logic [sitda_pkg::DIGIT_W-1:0] n_digit;
    logic [sitda_pkg::DIGIT_W-1:0] adj;

    // Add three before the shift when the digit would reach ten or more.
    assign adj   = (r_digit >= sitda_pkg::ADJ_LIMIT) ? r_digit + sitda_pkg::ADJ_ADD : r_digit;
    assign o_bit = adj[sitda_pkg::DIGIT_W-1];

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.conv) begin
            n_digit = {adj[sitda_pkg::DIGIT_W-2:0], i_bit};
        end else if (i_ctl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule

/* design/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per output transfer.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_valid, o_stall, i_value) takes one signed
// integer per transfer. The output channel (o_valid, i_stall, o_char_code,
// o_last_char) returns its decimal text: a minus sign for negative values,
// then the digits most significant first with no leading zeros, and
// o_last_char set on the final character. Zero gives a single '0'.
// The magnitude is taken as unsigned, so the most negative value converts.
// Sequence: after an input transfer a chain of ten BCD digit cells runs 32
// shift-add-3 steps, one per input bit. The chain then shifts its digits
// toward the top cell once per cycle, ten shifts in all, except while a
// stalled output holds a digit; leading zeros are dropped without waiting
// for the receiver, and each other digit leaves through the output register.
// A negative value first sends its minus sign from a separate sign state.
// The block returns to idle once the last digit enters the output register,
// and only then takes the next item.
// o_stall is high while an item is being converted or emitted.
// A stall on the output holds the output register and pauses the chain,
// but not the conversion or leading-zero drops. Reset clears the controller
// and the output valid; the chain needs none.
module signed_int_to_decimal_ascii (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [sitda_pkg::DATA_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [sitda_pkg::CHAR_W-1:0]       o_char_code,
    output logic                               o_last_char
);

    localparam int unsigned ND = sitda_pkg::NUM_DIGITS;

    sitda_pkg::t_state                  r_state, n_state;
    logic [sitda_pkg::DATA_W-1:0]       r_mag, n_mag;
    logic                               r_neg, n_neg;
    logic [sitda_pkg::CONV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [sitda_pkg::LEFT_W-1:0]       r_left, n_left;
    logic                               r_started, n_started;
    logic                               r_out_valid, n_out_valid;
    logic [sitda_pkg::CHAR_W-1:0]       r_out_char, n_out_char;
    logic                               r_out_last, n_out_last;

    sitda_pkg::t_cell_ctl               cell_ctl;
    logic [ND:0]                        chain_bit;
    logic [sitda_pkg::DIGIT_W-1:0]      chain_digit [ND+1];
    logic [sitda_pkg::DIGIT_W-1:0]      top_digit;
    logic                               in_xfer;
    logic                               out_free;

    // The input bit stream enters the bottom cell, most significant first;
    // during the digit shift the bottom cell fills with zero.
    assign chain_bit[0]   = r_mag[sitda_pkg::DATA_W-1];
    assign chain_digit[0] = '0;

    for (genvar g = 0; g < ND; g++) begin : g_cell
        sitda_digit_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_bit   (chain_bit[g]),
            .i_digit (chain_digit[g]),
            .o_bit   (chain_bit[g+1]),
            .o_digit (chain_digit[g+1])
        );
    end

    assign top_digit = chain_digit[ND];
    assign in_xfer   = i_valid && (r_state == sitda_pkg::S_IDLE);
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_started   = r_started;
        n_out_valid = r_out_valid && i_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        cell_ctl    = '{clear: 1'b0, conv: 1'b0, shift: 1'b0};

        case (r_state)
            sitda_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_neg          = i_value[sitda_pkg::DATA_W-1];
                    n_mag          = i_value[sitda_pkg::DATA_W-1] ? 0 - i_value : i_value;
                    n_cnt          = '0;
                    cell_ctl.clear = 1'b1;
                    n_state        = sitda_pkg::S_CONV;
                end
            end
            sitda_pkg::S_CONV: begin
                cell_ctl.conv = 1'b1;
                n_mag         = {r_mag[sitda_pkg::DATA_W-2:0], 1'b0};
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == sitda_pkg::CONV_CNT_W'(sitda_pkg::DATA_W - 1)) begin
                    n_left    = sitda_pkg::LEFT_W'(ND);
                    n_started = 1'b0;
                    n_state   = r_neg ? sitda_pkg::S_SIGN : sitda_pkg::S_DIGITS;
                end
            end
            sitda_pkg::S_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sitda_pkg::CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = sitda_pkg::S_DIGITS;
                end
            end
            sitda_pkg::S_DIGITS: begin
                if (!r_started && top_digit == '0 && r_left != sitda_pkg::LEFT_W'(1)) begin
                    // Leading zero: drop it without using the output.
                    cell_ctl.shift = 1'b1;
                    n_left         = r_left - 1'b1;
                end else if (out_free) begin
                    cell_ctl.shift = 1'b1;
                    n_left         = r_left - 1'b1;
                    n_started      = 1'b1;
                    n_out_valid    = 1'b1;
                    n_out_char     = sitda_pkg::CHAR_ZERO
                                   + {{(sitda_pkg::CHAR_W-sitda_pkg::DIGIT_W){1'b0}}, top_digit};
                    n_out_last     = (r_left == sitda_pkg::LEFT_W'(1));
                    if (r_left == sitda_pkg::LEFT_W'(1)) begin
                        n_state = sitda_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sitda_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sitda_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_left      <= '0;
            r_started   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_started   <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_stall     = (r_state != sitda_pkg::S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_char_code = r_out_char;
    assign o_last_char = r_out_last;

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for signed_int_to_decimal_ascii.
// Signed integers go into the block, and every character that comes back is
// checked against text that the bench works out for itself. The run covers
// edge values first, then random values under several traffic patterns.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Decimal radix used by the predictor and the value generator.
    localparam int unsigned RADIX        = 10;
    // Ceiling on the whole run; a correct run finishes far below this.
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    // Cycles the receiver refuses every character during the hold-off phase.
    localparam int unsigned HOLD_CYCLES  = 600;
    // Quiet cycles after the last character, well past one item's latency.
    localparam int unsigned TAIL_CYCLES  = 100;
    // Only the first few mismatches are printed, all of them are counted.
    localparam int unsigned MAX_REPORTS  = 40;

    // Traffic patterns. Each one sets how often the sender leaves a cycle
    // empty and how often the receiver stalls, in percent.
    typedef enum logic [2:0] {
        PH_FREE,
        PH_SEND_GAPS,
        PH_RECV_STALLS,
        PH_BOTH,
        PH_HOLD
    } t_phase;

    // One character of the expected decimal text.
    typedef struct packed {
        logic [sitda_pkg::CHAR_W-1:0] code;
        logic                         last;
    } t_text_char;

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_valid     = 1'b0;
    logic                                 o_stall;
    logic signed [sitda_pkg::DATA_W-1:0]  i_value     = '0;
    logic                                 o_valid;
    logic                                 i_stall     = 1'b0;
    logic [sitda_pkg::CHAR_W-1:0]         o_char_code;
    logic                                 o_last_char;

    t_phase                               phase       = PH_FREE;

    // Integers waiting to be offered, and the characters still owed.
    logic signed [sitda_pkg::DATA_W-1:0]  pending_values [$];
    t_text_char                           expected_chars [$];

    int unsigned               cycle_count      = 0;
    int unsigned               mismatch_count   = 0;
    int unsigned               ints_taken       = 0;
    int unsigned               negatives_taken  = 0;
    int unsigned               longest_runs     = 0;
    int unsigned               chars_checked    = 0;
    int unsigned               hold_left        = 0;
    logic                      hold_done        = 1'b0;

    signed_int_to_decimal_ascii i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned send_gap_pct(input t_phase ph);
        case (ph)
            PH_SEND_GAPS: return 56;
            PH_BOTH:      return 8;
            default:      return 0;
        endcase
    endfunction

    function automatic int unsigned recv_stall_pct(input t_phase ph);
        case (ph)
            PH_RECV_STALLS: return 56;
            PH_BOTH:        return 8;
            PH_HOLD:        return 8;
            default:        return 0;
        endcase
    endfunction

    // Works out the decimal text of one integer and queues it character by
    // character. The magnitude is formed as an unsigned number, which is what
    // lets the most negative value come out right.
    function automatic void predict_decimal_text(
        input logic signed [sitda_pkg::DATA_W-1:0] value
    );
        logic [sitda_pkg::DATA_W-1:0]  mag;
        logic [sitda_pkg::DIGIT_W-1:0] digits [sitda_pkg::NUM_DIGITS];
        int                            ndig;
        t_text_char                    ch;
        mag  = value[sitda_pkg::DATA_W-1] ? (sitda_pkg::DATA_W'(0) - value) : value;
        ndig = 0;
        // Digits are collected least significant first; zero still gives one.
        do begin
            digits[ndig] = sitda_pkg::DIGIT_W'(mag % RADIX);
            mag          = mag / RADIX;
            ndig++;
        end while (mag != 0 && ndig < sitda_pkg::NUM_DIGITS);
        if (value[sitda_pkg::DATA_W-1]) begin
            ch.code = sitda_pkg::CHAR_MINUS;
            ch.last = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            ch.code = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digits[i]);
            ch.last = (i == 0);
            expected_chars.push_back(ch);
        end
        if (value[sitda_pkg::DATA_W-1] && ndig == sitda_pkg::NUM_DIGITS) begin
            longest_runs++;
        end
    endfunction

    // Random integers with a spread of lengths: full-width values, values of
    // random bit length, short values, and powers of ten and the values just
    // below them, where the digit count changes.
    function automatic logic signed [sitda_pkg::DATA_W-1:0] random_value();
        logic signed [sitda_pkg::DATA_W-1:0] v;
        int unsigned                         pick;
        int unsigned                         k;
        pick = $urandom_range(3);
        case (pick)
            0: v = $urandom;
            1: v = $urandom >> $urandom_range(sitda_pkg::DATA_W - 1);
            2: v = $urandom_range(999);
            default: begin
                k = $urandom_range(sitda_pkg::NUM_DIGITS - 1);
                v = 1;
                repeat (k) v = v * RADIX;
                v = v - $urandom_range(1);
            end
        endcase
        if (pick != 0 && $urandom_range(1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    // Waits until the sender has nothing left to offer and every character
    // owed has come back.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_values.size() != 0 || i_valid || expected_chars.size() != 0);
    endtask

    task automatic run_random(input t_phase ph, input int unsigned count);
        phase = ph;
        repeat (count) pending_values.push_back(random_value());
        wait_drained();
    endtask

    // Sender. A transfer happens at an edge where i_valid is high and o_stall
    // is low; the integer's text is predicted right there. A held item stays
    // on the port until it is taken. Once the port is free, whether the next
    // cycle offers an item is drawn at random, even while o_stall is high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_value <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_decimal_text(i_value);
                ints_taken++;
                if (i_value[sitda_pkg::DATA_W-1]) begin
                    negatives_taken++;
                end
            end
            if (!i_valid || !o_stall) begin
                if (pending_values.size() != 0
                        && $urandom_range(99) >= send_gap_pct(phase)) begin
                    i_valid <= 1'b1;
                    i_value <= pending_values.pop_front();
                end else begin
                    // Idle cycles carry junk on the data port.
                    i_valid <= 1'b0;
                    i_value <= $urandom;
                end
            end
        end
    end

    // Receiver stall. On entering the hold-off phase the receiver refuses
    // everything for a long stretch while the sender keeps offering, so the
    // block backs up and holds its own input. Otherwise it stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (phase == PH_HOLD && !hold_done) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct(phase));
        end
    end

    // Checker. Every character transfer is matched, field by field, against
    // the oldest character still owed.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character %0d, last %0b",
                                          o_char_code, o_last_char));
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (o_char_code !== want.code) begin
                    report_mismatch($sformatf("char_code %0d, expected %0d",
                                              o_char_code, want.code));
                end
                if (o_last_char !== want.last) begin
                    report_mismatch($sformatf("last_char %0b, expected %0b (char %0d)",
                                              o_last_char, want.last, want.code));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters still owed",
                     cycle_count, expected_chars.size());
            $display("[signed_int_to_decimal_ascii] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Edge values: zero, one-digit values of both signs, the points where
        // the digit count changes, the largest and most negative integers,
        // ten-digit values with inner zeros, and alternating bit patterns so
        // that every input bit is seen at both levels.
        phase = PH_FREE;
        pending_values.push_back(32'sd0);
        pending_values.push_back(32'sd1);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(32'sd9);
        pending_values.push_back(-32'sd9);
        pending_values.push_back(32'sd10);
        pending_values.push_back(-32'sd10);
        pending_values.push_back(32'sd99);
        pending_values.push_back(32'sd100);
        pending_values.push_back(32'sd2147483647);
        pending_values.push_back(32'sh8000_0000);
        pending_values.push_back(-32'sd2147483647);
        pending_values.push_back(32'sd999999999);
        pending_values.push_back(32'sd1000000000);
        pending_values.push_back(-32'sd1000000000);
        pending_values.push_back(32'sd1000000001);
        pending_values.push_back(-32'sd2000000000);
        pending_values.push_back(32'sd1234567890);
        pending_values.push_back(-32'sd1234567890);
        pending_values.push_back(32'sh5555_5555);
        pending_values.push_back(32'shAAAA_AAAA);
        pending_values.push_back(32'sd1000000);
        wait_drained();

        // Random values under each traffic pattern in turn.
        run_random(PH_FREE,        50);
        run_random(PH_SEND_GAPS,   50);
        run_random(PH_RECV_STALLS, 50);
        run_random(PH_BOTH,        60);
        run_random(PH_HOLD,        50);

        // Let any stray character show up before the verdict.
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Converted %0d integers (%0d negative, %0d of eleven characters)",
                 ints_taken, negatives_taken, longest_runs);
        $display("into %0d checked characters, through free flow, gaps, stalls and a hold-off.",
                 chars_checked);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("[signed_int_to_decimal_ascii] OK");
        end else begin
            $display("[signed_int_to_decimal_ascii] ERROR");
        end
        $finish;
    end

endmodule
